/* src/cv3_pkg.sv */
package cv3_pkg;

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int POS_W      = 10;
  localparam int VAL_W      = 8;
  localparam int SIZE_REG_W = 11;
  localparam int TAPS       = 3;
  localparam int TAP_IDX_W  = $clog2(TAPS);
  localparam int MIN_SIZE   = 3;

  // Size registers after reset
  localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 11'd512;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KROW_TOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KROW_MID     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KROW_BOTTOM  = 3'd4;

  typedef logic [PIX_W-1:0] pix_t;

  // 3x3 window, indexed [row][column]; row 0 is the upper image row
  typedef logic [TAPS-1:0][TAPS-1:0][PIX_W-1:0] window_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] filtered_value;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_column;
    logic             frame_done;
  } out_word_t;

endpackage

/* src/cv3_stream_if.sv */
interface cv3_stream_if #(
  parameter type T = logic [7:0]
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/cv3_cfg_if.sv */
interface cv3_cfg_if #(
  parameter int DATA_W = 24
);
  logic                           valid;
  logic                           ready;
  logic [cv3_pkg::CFG_IDX_W-1:0]  index;
  logic [DATA_W-1:0]              data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/cv3_ram.sv */
module cv3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/cv3_mac.sv */
module cv3_mac #(
  parameter int COEF_BITS = 8
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   start,
  input  cv3_pkg::window_t                                       window,
  input  logic [cv3_pkg::TAPS-1:0][cv3_pkg::TAPS-1:0][COEF_BITS-1:0] coefs,
  output logic                                                   done,
  output logic signed [cv3_pkg::PIX_W+COEF_BITS+3:0]             sum,
  output logic signed [COEF_BITS+3:0]                            ksum
);

  localparam int SUM_W  = cv3_pkg::PIX_W + COEF_BITS + 4;
  localparam int K_W    = COEF_BITS + 4;
  localparam int PROD_W = cv3_pkg::PIX_W + 1 + COEF_BITS;
  localparam int IW     = cv3_pkg::TAP_IDX_W;
  localparam logic [IW-1:0] TAP_LAST = IW'(cv3_pkg::TAPS - 1);

  logic                     run_r, run_nxt;
  logic                     done_r, done_nxt;
  logic [IW-1:0]            tr_r, tr_nxt;
  logic [IW-1:0]            tc_r, tc_nxt;
  logic signed [SUM_W-1:0]  acc_r, acc_nxt;
  logic signed [K_W-1:0]    kacc_r, kacc_nxt;

  logic signed [COEF_BITS-1:0]  cf;
  logic signed [PROD_W-1:0]     prod;

  // One tap per cycle: coefficient times window pixel
  assign cf   = $signed(coefs[tr_r][tc_r]);
  assign prod = $signed({1'b0, window[tr_r][tc_r]}) * cf;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    tr_nxt   = tr_r;
    tc_nxt   = tc_r;
    acc_nxt  = acc_r;
    kacc_nxt = kacc_r;
    if (start) begin
      run_nxt  = 1'b1;
      tr_nxt   = '0;
      tc_nxt   = '0;
      acc_nxt  = '0;
      kacc_nxt = '0;
    end else if (run_r) begin
      acc_nxt  = acc_r + SUM_W'(prod);
      kacc_nxt = kacc_r + K_W'(cf);
      if (tc_r == TAP_LAST) begin
        tc_nxt = '0;
        if (tr_r == TAP_LAST) begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
        end else begin
          tr_nxt = tr_r + 1'b1;
        end
      end else begin
        tc_nxt = tc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      tr_r   <= '0;
      tc_r   <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      tr_r   <= tr_nxt;
      tc_r   <= tc_nxt;
    end
    acc_r  <= acc_nxt;
    kacc_r <= kacc_nxt;
  end

  assign done = done_r;
  assign sum  = acc_r;
  assign ksum = kacc_r;

endmodule

/* src/cv3_div.sv */
module cv3_div #(
  parameter int COEF_BITS = 8
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic signed [cv3_pkg::PIX_W+COEF_BITS+3:0] dividend,
  input  logic signed [COEF_BITS+3:0]                divisor,
  output logic                                       done,
  output logic [cv3_pkg::VAL_W-1:0]                  quotient
);

  localparam int SUM_W = cv3_pkg::PIX_W + COEF_BITS + 4;
  localparam int K_W   = COEF_BITS + 4;
  localparam int CNT_W = $clog2(SUM_W + 1);

  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [K_W-1:0]     rem_r, rem_nxt;
  logic [K_W-1:0]     dvs_r, dvs_nxt;
  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic               neg_r, neg_nxt;

  logic [SUM_W-1:0]   dvd_mag;
  logic [K_W-1:0]     dvs_mag;
  logic               dvs_zero;
  logic [K_W-1:0]     rem_sh;
  logic               fits;
  logic [SUM_W-1:0]   quo_neg;

  assign dvd_mag  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign dvs_mag  = divisor[K_W-1] ? K_W'(-divisor) : K_W'(divisor);
  assign dvs_zero = (divisor == '0);

  // Restoring step: one quotient bit per cycle
  assign rem_sh = {rem_r[K_W-2:0], quo_r[SUM_W-1]};
  assign fits   = (rem_sh >= dvs_r);

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    if (start) begin
      run_nxt = 1'b1;
      rem_nxt = '0;
      dvs_nxt = dvs_mag;
      // zero coefficient sum: the raw sum passes through
      if (dvs_zero) begin
        cnt_nxt = '0;
        quo_nxt = SUM_W'(dividend);
        neg_nxt = 1'b0;
      end else begin
        cnt_nxt = CNT_W'(SUM_W);
        quo_nxt = dvd_mag;
        neg_nxt = dividend[SUM_W-1] ^ divisor[K_W-1];
      end
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        rem_nxt = fits ? (rem_sh - dvs_r) : rem_sh;
        quo_nxt = {quo_r[SUM_W-2:0], fits};
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
  end

  // Truncation toward zero: negate the magnitude quotient when signs differ
  assign quo_neg  = -quo_r;
  assign quotient = neg_r ? quo_neg[cv3_pkg::VAL_W-1:0] : quo_r[cv3_pkg::VAL_W-1:0];
  assign done     = done_r;

endmodule

/* src/conv3x3_kernel_normalized_top.sv */
// 3x3 convolution on a raster pixel stream, two previous rows in one line RAM.
// Border pixel: after acceptance (RAM read) the update state runs, then the next word is taken.
// Interior pixel: the result word follows the update state, the nine-tap serial MAC and the
// bit-serial divider (which skips its shift steps for a zero kernel sum); the next word is
// taken once the result is loaded, held off while an earlier result waits at the output.
// Reset loads default sizes and kernel, clears counters and window; line RAM is not cleared.
module conv3x3_kernel_normalized_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int COEF_BITS  = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  cv3_stream_if.sink      in_chan,
  cv3_stream_if.source    out_chan,
  cv3_cfg_if.sink         cfg_bus
);

  localparam int PIX_W  = cv3_pkg::PIX_W;
  localparam int POS_W  = cv3_pkg::POS_W;
  localparam int TAPS   = cv3_pkg::TAPS;
  localparam int SREG_W = cv3_pkg::SIZE_REG_W;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int KROW_W = TAPS * COEF_BITS;
  localparam int SUM_W  = PIX_W + COEF_BITS + 4;
  localparam int K_W    = COEF_BITS + 4;
  localparam int MW_W   = $clog2(MAX_WIDTH + 1);
  localparam int MH_W   = $clog2(MAX_HEIGHT + 1);
  localparam int MX_W   = (MW_W > MH_W) ? MW_W : MH_W;
  localparam int CMP_W  = ((MX_W > SREG_W) ? MX_W : SREG_W) + 1;

  localparam logic [KROW_W-1:0] KROW_EDGE_RST = {KROW_W{1'b1}};
  localparam logic [KROW_W-1:0] KROW_MID_RST  =
    {{COEF_BITS{1'b1}}, COEF_BITS'(1), {COEF_BITS{1'b1}}};

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [PIX_W-1:0]             pixel_r;
  logic [CW-1:0]                col_r, col_nxt;
  logic [RW-1:0]                row_r, row_nxt;
  logic [SREG_W-1:0]            width_r, height_r;
  logic [TAPS-1:0][KROW_W-1:0]  kernel_r;
  cv3_pkg::window_t             win_r;
  logic [POS_W-1:0]             res_row_r, res_col_r;
  logic                         res_last_r;
  logic                         out_valid_r, out_valid_nxt;
  cv3_pkg::out_word_t           out_word_r;

  logic                         in_acc;
  logic                         out_load;
  logic [2*PIX_W-1:0]           ram_rdata;
  logic [PIX_W-1:0]             up2, up1;
  logic [CMP_W-1:0]             w_eff, h_eff, c_ext, r_ext, c_inc, r_inc, r_m1, c_m1;
  logic                         interior, last_pos;
  logic                         mac_start, mac_done, div_start, div_done;
  logic signed [SUM_W-1:0]      mac_sum;
  logic signed [K_W-1:0]        mac_ksum;
  logic [cv3_pkg::VAL_W-1:0]    div_q;
  logic [TAPS-1:0][TAPS-1:0][COEF_BITS-1:0] coefs;

  assign in_acc         = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_bus.ready  = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= cv3_pkg::SIZE_RESET;
      height_r    <= cv3_pkg::SIZE_RESET;
      kernel_r[0] <= KROW_EDGE_RST;
      kernel_r[1] <= KROW_MID_RST;
      kernel_r[2] <= KROW_EDGE_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        cv3_pkg::REG_IMAGE_WIDTH:  width_r     <= cfg_bus.data[SREG_W-1:0];
        cv3_pkg::REG_IMAGE_HEIGHT: height_r    <= cfg_bus.data[SREG_W-1:0];
        cv3_pkg::REG_KROW_TOP:     kernel_r[0] <= cfg_bus.data[KROW_W-1:0];
        cv3_pkg::REG_KROW_MID:     kernel_r[1] <= cfg_bus.data[KROW_W-1:0];
        cv3_pkg::REG_KROW_BOTTOM:  kernel_r[2] <= cfg_bus.data[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Line RAM: upper byte is the row two above, lower byte the row above
  cv3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (state_r == ST_UPD),
    .waddr (col_r),
    .wdata ({up1, pixel_r}),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign up2 = ram_rdata[2*PIX_W-1:PIX_W];
  assign up1 = ram_rdata[PIX_W-1:0];

  // Effective frame size and position tests
  always_comb begin
    if (width_r < SREG_W'(cv3_pkg::MIN_SIZE)) begin
      w_eff = CMP_W'(cv3_pkg::MIN_SIZE);
    end else if (CMP_W'(width_r) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(width_r);
    end
    if (height_r < SREG_W'(cv3_pkg::MIN_SIZE)) begin
      h_eff = CMP_W'(cv3_pkg::MIN_SIZE);
    end else if (CMP_W'(height_r) > CMP_W'(MAX_HEIGHT)) begin
      h_eff = CMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = CMP_W'(height_r);
    end
  end

  assign c_ext    = CMP_W'(col_r);
  assign r_ext    = CMP_W'(row_r);
  assign c_inc    = c_ext + CMP_W'(1);
  assign r_inc    = r_ext + CMP_W'(1);
  assign c_m1     = c_ext - CMP_W'(1);
  assign r_m1     = r_ext - CMP_W'(1);
  assign interior = (r_ext >= CMP_W'(2)) && (c_ext >= CMP_W'(2)) &&
                    (r_ext < h_eff) && (c_ext < w_eff);
  assign last_pos = (r_inc == h_eff) && (c_inc == w_eff);

  // Raster counters advance in the update cycle
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (state_r == ST_UPD) begin
      if (c_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
      end else begin
        col_nxt = c_inc[CW-1:0];
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = interior ? ST_MAC : ST_IDLE;
      ST_MAC:  if (mac_done) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign mac_start = (state_r == ST_UPD) && interior;
  assign div_start = (state_r == ST_MAC) && mac_done;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      win_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      // window shifts left, new column from RAM and the incoming pixel
      if (state_r == ST_UPD) begin
        for (int i = 0; i < TAPS; i++) begin
          win_r[i][0] <= win_r[i][1];
          win_r[i][1] <= win_r[i][2];
        end
        win_r[0][2] <= up2;
        win_r[1][2] <= up1;
        win_r[2][2] <= pixel_r;
      end
    end
  end

  // Pixel and result position capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pixel_r <= in_chan.data.pixel;
    end
    if (mac_start) begin
      res_row_r  <= r_m1[POS_W-1:0];
      res_col_r  <= c_m1[POS_W-1:0];
      res_last_r <= last_pos;
    end
  end

  // Coefficient rows map directly onto [row][column] taps
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      coefs[i] = kernel_r[i];
    end
  end

  cv3_mac #(
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mac_start),
    .window (win_r),
    .coefs  (coefs),
    .done   (mac_done),
    .sum    (mac_sum),
    .ksum   (mac_ksum)
  );

  cv3_div #(
    .COEF_BITS (COEF_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mac_sum),
    .divisor  (mac_ksum),
    .done     (div_done),
    .quotient (div_q)
  );

  // Output word register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_word_r.filtered_value <= div_q;
      out_word_r.out_row        <= res_row_r;
      out_word_r.out_column     <= res_col_r;
      out_word_r.frame_done     <= res_last_r;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_word_r;

endmodule

/* dv/conv3x3_kernel_normalized_top_tb.sv */
`timescale 1ns / 1ps

module conv3x3_kernel_normalized_top_tb;
  import cv3_pkg::*;

  localparam int MAX_SIZE       = 1024;
  localparam int COEF_BITS      = 8;
  localparam int KROW_W         = TAPS * COEF_BITS;
  localparam int CFG_LAST_INDEX = (1 << CFG_IDX_W) - 1;
  localparam int DRAIN_CYCLES   = 48;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS  = 1100;

  localparam logic [KROW_W-1:0] KROW_RESET_EDGE = 24'hFFFFFF;
  localparam logic [KROW_W-1:0] KROW_RESET_MID  = 24'hFF01FF;

  // Pixel source used for one frame
  typedef enum logic [1:0] {
    FILL_CONST,
    FILL_RANDOM,
    FILL_EXTREME
  } fill_e;

  // One row of the directed table; pixel_count 0 runs to the end of the frame
  typedef struct packed {
    bit                    write_cfg;
    logic [SIZE_REG_W-1:0] width;
    logic [SIZE_REG_W-1:0] height;
    logic [KROW_W-1:0]     k_top;
    logic [KROW_W-1:0]     k_mid;
    logic [KROW_W-1:0]     k_bot;
    int                    pixel_count;
    fill_e                 fill;
    pix_t                  fill_value;
    bit                    typed;
    pix_t                  typed_value;
  } frame_step_t;

  localparam int DIRECTED_ROWS = 15;
  localparam frame_step_t DIRECTED [DIRECTED_ROWS] = '{
    // reset sizes and kernel, stop right after the first interior pixel
    '{1'b0, 11'd0, 11'd0, 24'h0, 24'h0, 24'h0, 1027, FILL_CONST, 8'd10, 1'b1, 8'd10},
    // shrink width below minimum mid-frame, frame ends at once
    '{1'b1, 11'd2, 11'd3, 24'h010101, 24'h010101, 24'h010101, 0, FILL_RANDOM, 8'd0,
      1'b0, 8'd0},
    '{1'b1, 11'd3, 11'd3, 24'h010101, 24'h010101, 24'h010101, 0, FILL_CONST, 8'd255,
      1'b1, 8'd255},
    '{1'b1, 11'd3, 11'd3, 24'h808080, 24'h808080, 24'h808080, 0, FILL_CONST, 8'd255,
      1'b1, 8'd255},
    '{1'b1, 11'd4, 11'd3, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 0, FILL_CONST, 8'd0,
      1'b1, 8'd0},
    // zero-sum kernel, flat image gives zero
    '{1'b1, 11'd5, 11'd4, 24'h000100, 24'h01FC01, 24'h000100, 0, FILL_CONST, 8'd200,
      1'b1, 8'd0},
    '{1'b1, 11'd5, 11'd4, 24'h000100, 24'h01FC01, 24'h000100, 0, FILL_EXTREME, 8'd0,
      1'b0, 8'd0},
    // zero-sum pass-through that wraps
    '{1'b1, 11'd4, 11'd4, 24'h00007F, 24'h000000, 24'h000081, 0, FILL_RANDOM, 8'd0,
      1'b0, 8'd0},
    // positive divisor, mostly negative sums: truncation toward zero
    '{1'b1, 11'd6, 11'd5, 24'h808080, 24'h7F7F7F, 24'h050505, 0, FILL_RANDOM, 8'd0,
      1'b0, 8'd0},
    // kernel swapped mid-frame
    '{1'b1, 11'd6, 11'd6, KROW_RESET_EDGE, KROW_RESET_MID, KROW_RESET_EDGE, 20,
      FILL_RANDOM, 8'd0, 1'b0, 8'd0},
    '{1'b1, 11'd6, 11'd6, 24'h03FD02, 24'hF90A05, 24'h01FE04, 0, FILL_RANDOM, 8'd0,
      1'b0, 8'd0},
    // height shrunk below the current row mid-frame
    '{1'b1, 11'd5, 11'd8, 24'h010101, 24'h010101, 24'h010101, 22, FILL_RANDOM, 8'd0,
      1'b0, 8'd0},
    '{1'b1, 11'd5, 11'd4, 24'h010101, 24'h010101, 24'h010101, 0, FILL_RANDOM, 8'd0,
      1'b0, 8'd0},
    // widest and tallest frames, sizes above the maximum clamp
    '{1'b1, 11'd2047, 11'd3, KROW_RESET_EDGE, KROW_RESET_MID, KROW_RESET_EDGE, 0,
      FILL_RANDOM, 8'd0, 1'b0, 8'd0},
    '{1'b1, 11'd1, 11'd2047, 24'h02FF03, 24'hFE04FD, 24'h01FF02, 0, FILL_RANDOM, 8'd0,
      1'b0, 8'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cv3_stream_if #(.T(in_word_t))  in_if ();
  cv3_stream_if #(.T(out_word_t)) out_if ();
  cv3_cfg_if #(.DATA_W(KROW_W))   cfg_if ();

  conv3x3_kernel_normalized_top #(
    .MAX_WIDTH  (MAX_SIZE),
    .MAX_HEIGHT (MAX_SIZE),
    .COEF_BITS  (COEF_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_bus  (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model of the filter: registers, line stores, window and position
  logic [SIZE_REG_W-1:0] width_reg;
  logic [SIZE_REG_W-1:0] height_reg;
  logic [KROW_W-1:0]     krow [TAPS];
  pix_t                  row_prev [MAX_SIZE];
  pix_t                  row_prev2 [MAX_SIZE];
  pix_t                  win [TAPS][TAPS];
  int unsigned           pred_row;
  int unsigned           pred_col;

  out_word_t   filtered_q [$];
  int unsigned pixels_sent = 0;
  int          error_count = 0;
  bit          typed_on = 1'b0;
  pix_t        typed_val = '0;
  bit          in_no_gaps = 1'b0;
  bit          out_no_stall = 1'b0;
  logic        sink_ready = 1'b0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  out_word_t   seen_word;
  out_word_t   due_word;

  function automatic int unsigned used_size(input logic [SIZE_REG_W-1:0] raw,
                                            input int unsigned max_size);
    if (raw < MIN_SIZE) return MIN_SIZE;
    if (raw > max_size) return max_size;
    return raw;
  endfunction

  // Advance the model by one pixel; got is set when an interior result is due
  function automatic void convolve_pixel(input pix_t p, output bit got,
                                         output out_word_t res);
    int unsigned w, h, r, c;
    int          i, j;
    pix_t        up2, up1;
    longint      acc, ksum, cf, q;
    w   = used_size(width_reg, MAX_SIZE);
    h   = used_size(height_reg, MAX_SIZE);
    r   = pred_row;
    c   = pred_col;
    up2 = '0;
    up1 = '0;
    got = 1'b0;
    res = '0;
    if (c < MAX_SIZE) begin
      up2 = row_prev2[c];
      up1 = row_prev[c];
      row_prev2[c] = up1;
      row_prev[c]  = p;
    end
    for (i = 0; i < TAPS; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = p;

    if (r >= 2 && c >= 2 && r < h && c < w) begin
      acc  = 0;
      ksum = 0;
      for (i = 0; i < TAPS; i++) begin
        for (j = 0; j < TAPS; j++) begin
          cf   = longint'($signed(krow[i][COEF_BITS*j +: COEF_BITS]));
          ksum += cf;
          acc  += longint'(win[i][j]) * cf;
        end
      end
      q = (ksum == 0) ? acc : acc / ksum;
      res.filtered_value = q[VAL_W-1:0];
      res.out_row        = POS_W'(r - 1);
      res.out_column     = POS_W'(c - 1);
      res.frame_done     = (r == h - 1 && c == w - 1);
      got = 1'b1;
    end

    // position wraps at the end of the current row and frame
    if (c + 1 >= w) begin
      pred_col = 0;
      pred_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      pred_col = c + 1;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic pix_t make_pixel(input fill_e mode, input pix_t v);
    case (mode)
      FILL_CONST:   return v;
      FILL_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
      default:      return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [SIZE_REG_W-1:0] rand_size(input int unsigned common_max,
                                                      input int unsigned wide_max);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return SIZE_REG_W'($urandom_range(0, MIN_SIZE - 1));
    if (roll < 20) return SIZE_REG_W'($urandom_range(common_max + 1, wide_max));
    return SIZE_REG_W'($urandom_range(MIN_SIZE, common_max));
  endfunction

  // Nine coefficients, row i at bits 24i, column j at 8j within the row
  function automatic logic [TAPS*KROW_W-1:0] rand_kernel();
    logic signed [COEF_BITS-1:0] cf [TAPS*TAPS];
    logic [TAPS*KROW_W-1:0]      packed_k;
    int                          kind, n, total;
    kind  = $urandom_range(0, 3);
    total = 0;
    for (n = 0; n < TAPS * TAPS; n++) begin
      case (kind)
        0: cf[n] = COEF_BITS'($urandom_range(0, 255));
        3: begin
          case ($urandom_range(0, 4))
            0:       cf[n] = -128;
            1:       cf[n] = 127;
            2:       cf[n] = -1;
            3:       cf[n] = 1;
            default: cf[n] = 0;
          endcase
        end
        default: cf[n] = COEF_BITS'($urandom_range(0, 8) - 4);
      endcase
      if (n != TAPS * TAPS / 2) total += int'(cf[n]);
    end
    // zero-sum variant: center cancels the rest
    if (kind == 2) cf[TAPS * TAPS / 2] = COEF_BITS'(-total);
    for (n = 0; n < TAPS * TAPS; n++) packed_k[COEF_BITS*n +: COEF_BITS] = cf[n];
    return packed_k;
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KROW_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_IMAGE_WIDTH:  width_reg  = value[SIZE_REG_W-1:0];
      REG_IMAGE_HEIGHT: height_reg = value[SIZE_REG_W-1:0];
      REG_KROW_TOP:     krow[0] = value;
      REG_KROW_MID:     krow[1] = value;
      REG_KROW_BOTTOM:  krow[2] = value;
      default: ;
    endcase
  endtask

  task automatic send_pixel(input pix_t p);
    int unsigned gap;
    bit          got;
    out_word_t   res;
    gap = in_no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= p;
    do @(posedge clk); while (!in_if.ready);
    pixels_sent++;
    convolve_pixel(p, got, res);
    if (got) begin
      if (typed_on) res.filtered_value = typed_val;
      filtered_q.push_back(res);
    end
  endtask

  task automatic run_pixels(input fill_e mode, input pix_t v, input int count);
    if (count == 0) begin
      do send_pixel(make_pixel(mode, v)); while (!(pred_row == 0 && pred_col == 0));
    end else begin
      repeat (count) send_pixel(make_pixel(mode, v));
    end
  endtask

  // Block is idle once all results are in and the last border word has settled
  task automatic wait_for_idle();
    in_if.valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side backpressure
  assign out_if.ready = sink_ready;

  always @(posedge clk) begin
    if (stall_left != 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      sink_ready <= 1'b1;
      if (!out_no_stall && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen_word = out_if.data;
      if (filtered_q.size() == 0) begin
        note_error($sformatf("unexpected word value %0d row %0d col %0d done %0d",
                             seen_word.filtered_value, seen_word.out_row,
                             seen_word.out_column, seen_word.frame_done));
      end else begin
        due_word = filtered_q.pop_front();
        if (seen_word.filtered_value !== due_word.filtered_value)
          note_error($sformatf("filtered_value exp %0d got %0d (row %0d col %0d)",
                               due_word.filtered_value, seen_word.filtered_value,
                               due_word.out_row, due_word.out_column));
        if (seen_word.out_row !== due_word.out_row)
          note_error($sformatf("out_row exp %0d got %0d", due_word.out_row,
                               seen_word.out_row));
        if (seen_word.out_column !== due_word.out_column)
          note_error($sformatf("out_column exp %0d got %0d", due_word.out_column,
                               seen_word.out_column));
        if (seen_word.frame_done !== due_word.frame_done)
          note_error($sformatf("frame_done exp %0d got %0d (row %0d col %0d)",
                               due_word.frame_done, seen_word.frame_done,
                               due_word.out_row, due_word.out_column));
      end
    end
  end

  // Watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    frame_step_t            step;
    logic [TAPS*KROW_W-1:0] kern;
    int unsigned            random_start;
    int unsigned            roll;
    fill_e                  mode;
    bit                     first_frame;

    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;

    // model state after reset
    width_reg  = SIZE_RESET;
    height_reg = SIZE_RESET;
    krow[0]    = KROW_RESET_EDGE;
    krow[1]    = KROW_RESET_MID;
    krow[2]    = KROW_RESET_EDGE;
    foreach (row_prev[k]) begin
      row_prev[k]  = '0;
      row_prev2[k] = '0;
    end
    foreach (win[a, b]) win[a][b] = '0;
    pred_row = 0;
    pred_col = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames
    for (int s = 0; s < DIRECTED_ROWS; s++) begin
      step = DIRECTED[s];
      if (step.write_cfg) begin
        wait_for_idle();
        write_reg(REG_IMAGE_WIDTH, KROW_W'(step.width));
        write_reg(REG_IMAGE_HEIGHT, KROW_W'(step.height));
        write_reg(REG_KROW_TOP, step.k_top);
        write_reg(REG_KROW_MID, step.k_mid);
        write_reg(REG_KROW_BOTTOM, step.k_bot);
        cfg_if.valid <= 1'b0;
      end
      typed_on     = step.typed;
      typed_val    = step.typed_value;
      in_no_gaps   = (s % 3 == 0);
      out_no_stall = (s % 4 == 1);
      run_pixels(step.fill, step.fill_value, step.pixel_count);
    end
    typed_on = 1'b0;

    // Random frames, one configuration each
    random_start = pixels_sent;
    first_frame  = 1'b1;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      wait_for_idle();
      kern = rand_kernel();
      write_reg(REG_IMAGE_WIDTH, KROW_W'(rand_size(12, 40)));
      write_reg(REG_IMAGE_HEIGHT, KROW_W'(rand_size(7, 16)));
      if (first_frame || $urandom_range(0, 3) != 0) write_reg(REG_KROW_TOP, kern[0 +: KROW_W]);
      if (first_frame || $urandom_range(0, 3) != 0)
        write_reg(REG_KROW_MID, kern[KROW_W +: KROW_W]);
      if (first_frame || $urandom_range(0, 3) != 0)
        write_reg(REG_KROW_BOTTOM, kern[2*KROW_W +: KROW_W]);
      // writes past the register list are dropped
      if ($urandom_range(0, 5) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_KROW_BOTTOM + 1, CFG_LAST_INDEX)),
                  KROW_W'($urandom));
      cfg_if.valid <= 1'b0;
      first_frame  = 1'b0;
      in_no_gaps   = ($urandom_range(0, 4) == 0);
      out_no_stall = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 99);
      mode = (roll < 70) ? FILL_RANDOM : (roll < 85) ? FILL_EXTREME : FILL_CONST;
      run_pixels(mode, pix_t'($urandom_range(0, 255)), 0);
    end

    wait_for_idle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
